// ===== hw/rtl/sfp_pkg.sv =====
// Shared types and constants for the sensor frame parser.
package sfp_pkg;

  localparam int FracBitsDefault = 16;
  localparam int DivBits = 44;
  localparam int AddrBits = 5;

  localparam logic [7:0] HeaderReset = 8'hA5;
  localparam logic [15:0] GapReset = 16'd10;
  localparam logic [15:0] MinReset = 16'd5;
  localparam logic [15:0] MaxReset = 16'd200;
  localparam logic [16:0] PosWeightReset = 17'd36045;
  localparam logic [16:0] VelWeightReset = 17'd29491;

  localparam logic [2:0] REG_HEADER = 3'd0;
  localparam logic [2:0] REG_GAP = 3'd1;
  localparam logic [2:0] REG_MIN = 3'd2;
  localparam logic [2:0] REG_MAX = 3'd3;
  localparam logic [2:0] REG_POS_W = 3'd4;
  localparam logic [2:0] REG_VEL_W = 3'd5;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FAULT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [15:0] gap_timeout_ms;
    logic [15:0] min_interval_ms;
    logic [15:0] max_interval_ms;
    logic [16:0] position_weight;
    logic [16:0] velocity_weight;
  } cfg_t;

  typedef struct packed {
    logic  take;
    logic  reject;
    logic  conv_p;
    logic  conv_v;
    logic  seed;
    logic  mul_p;
    logic  add_p;
    logic  reload_v;
    logic  div_init;
    logic  div_step;
    logic  div_done;
    logic  mul_v;
    logic  add_v;
    logic  finish;
    logic  load_out;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic nonfinite;
    logic seeded;
    logic in_window;
    logic above_max;
    logic div_last;
  } sts_t;

endpackage

// ===== hw/rtl/sfp_regs.sv =====
// Configuration register file behind the APB-style port.
module sfp_regs import sfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output cfg_t                cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[AddrBits-1:2];
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= HeaderReset;
      cfg.gap_timeout_ms <= GapReset;
      cfg.min_interval_ms <= MinReset;
      cfg.max_interval_ms <= MaxReset;
      cfg.position_weight <= PosWeightReset;
      cfg.velocity_weight <= VelWeightReset;
    end else if (wr) begin
      case (idx)
        REG_HEADER: cfg.header_byte <= pwdata[7:0];
        REG_GAP:    cfg.gap_timeout_ms <= pwdata[15:0];
        REG_MIN:    cfg.min_interval_ms <= pwdata[15:0];
        REG_MAX:    cfg.max_interval_ms <= pwdata[15:0];
        REG_POS_W:  cfg.position_weight <= pwdata[16:0];
        REG_VEL_W:  cfg.velocity_weight <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADER: prdata = {24'd0, cfg.header_byte};
      REG_GAP:    prdata = {16'd0, cfg.gap_timeout_ms};
      REG_MIN:    prdata = {16'd0, cfg.min_interval_ms};
      REG_MAX:    prdata = {16'd0, cfg.max_interval_ms};
      REG_POS_W:  prdata = {15'd0, cfg.position_weight};
      REG_VEL_W:  prdata = {15'd0, cfg.velocity_weight};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/sfp_dp.sv =====
// Datapath: byte framing, float conversion, smoothing and the rate divider.
module sfp_dp import sfp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] now_ms,
  input  logic        line_fault,
  output logic [1:0]  report_kind,
  output logic [31:0] position_fx,
  output logic [31:0] velocity_mm_s,
  output logic [31:0] frames_published,
  output logic [31:0] faults_seen
);

  logic [3:0]         frame_pos;
  logic [7:0]         payload [8];
  logic [31:0]        last_byte_time;
  logic               seeded;
  logic signed [31:0] sp;
  logic signed [31:0] sv;
  logic [31:0]        last_sample_time;
  logic [31:0]        pub_cnt;
  logic [31:0]        fault_cnt;

  logic [31:0]        now_r;
  logic [31:0]        dt_r;
  logic signed [31:0] pos_r;
  logic signed [31:0] vel_r;
  logic signed [31:0] prev_r;
  logic signed [31:0] der_r;
  logic signed [50:0] prod_r;
  logic [DivBits-1:0] dq;
  logic [16:0]        rem;
  logic               neg_r;
  logic [5:0]         cnt;

  logic        gap;
  logic [3:0]  fp_eff;
  logic [31:0] word_p;
  logic [31:0] word_v;
  logic [31:0] conv_in;
  logic signed [31:0] conv_out;
  logic [15:0] lo;

  assign gap = (frame_pos != 4'd0) && ((now_ms - last_byte_time) > {16'd0, cfg.gap_timeout_ms});
  assign fp_eff = gap ? 4'd0 : frame_pos;
  assign word_p = {payload[3], payload[2], payload[1], payload[0]};
  assign word_v = {payload[7], payload[6], payload[5], payload[4]};
  assign lo = (cfg.min_interval_ms == 16'd0) ? 16'd1 : cfg.min_interval_ms;

  assign sts.frame_done = !line_fault && (fp_eff == 4'd8);
  assign sts.nonfinite = (word_p[30:23] == 8'hFF) || (word_v[30:23] == 8'hFF);
  assign sts.seeded = seeded;
  assign sts.in_window = (dt_r >= {16'd0, lo}) && (dt_r <= {16'd0, cfg.max_interval_ms});
  assign sts.above_max = dt_r > {16'd0, cfg.max_interval_ms};
  assign sts.div_last = (cnt == 6'(DivBits - 1));

  // Float to fixed point millimetres, round half away from zero, saturate.
  assign conv_in = cmd.conv_v ? word_v : word_p;
  always_comb begin
    logic [7:0]         ex;
    logic [63:0]        mant;
    logic signed [11:0] sh;
    logic [5:0]         rr;
    logic [63:0]        mag;
    ex = conv_in[30:23];
    mant = {40'd0, (ex != 8'd0), conv_in[22:0]} * 64'd10;
    if (ex == 8'd0) ex = 8'd1;
    sh = $signed({4'd0, ex}) - 12'sd150 + 12'(FRAC_BITS);
    rr = 6'((-sh) & 12'sh3F);
    if (sh >= 12'sd8) mag = 64'd1 << 40;
    else if (sh >= 12'sd0) mag = mant << sh[2:0];
    else if (sh <= -12'sd40) mag = 64'd0;
    else mag = (mant + (64'd1 << (rr - 6'd1))) >> rr;
    if (conv_in[31]) begin
      if (mag >= 64'h8000_0000) conv_out = 32'sh8000_0000;
      else conv_out = 32'(-$signed(mag));
    end else begin
      if (mag > 64'h7FFF_FFFF) conv_out = 32'sh7FFF_FFFF;
      else conv_out = mag[31:0];
    end
  end

  // Blend step: cur plus rounded product, saturated.
  logic signed [31:0] blend_out;
  always_comb begin
    logic signed [51:0] p;
    logic signed [51:0] r;
    logic signed [51:0] s;
    p = 52'(prod_r);
    if (!p[51]) r = (p + 52'sd32768) >>> 16;
    else r = -(((-p) + 52'sd32768) >>> 16);
    s = (cmd.add_v ? 52'(sv) : 52'(sp)) + r;
    if (s > 52'sh7FFF_FFFF) blend_out = 32'sh7FFF_FFFF;
    else if (s < -52'sh8000_0000) blend_out = 32'sh8000_0000;
    else blend_out = s[31:0];
  end

  logic [16:0] wp;
  logic [16:0] wv;
  assign wp = (cfg.position_weight > 17'd65536) ? 17'd65536 : cfg.position_weight;
  assign wv = (cfg.velocity_weight > 17'd65536) ? 17'd65536 : cfg.velocity_weight;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  assign mul_a = cmd.mul_v ? (33'(der_r) - 33'(sv)) : (33'(pos_r) - 33'(sp));
  assign mul_b = $signed({1'b0, cmd.mul_v ? wv : wp});

  logic signed [43:0] num;
  logic [43:0]        num_mag;
  assign num = 44'(33'(sp) - 33'(prev_r)) * 44'sd1000;
  assign num_mag = num[43] ? 44'(-num) : 44'(num);

  logic [16:0] rem_sh;
  assign rem_sh = {rem[15:0], dq[DivBits-1]};

  logic signed [31:0] q_sat;
  always_comb begin
    if (neg_r) q_sat = (dq > 44'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed(dq));
    else q_sat = (dq > 44'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dq[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= 4'd0;
      for (int i = 0; i < 8; i++) payload[i] <= 8'd0;
      last_byte_time <= 32'd0;
      seeded <= 1'b0;
      sp <= 32'sd0;
      sv <= 32'sd0;
      last_sample_time <= 32'd0;
      pub_cnt <= 32'd0;
      fault_cnt <= 32'd0;
      cnt <= 6'd0;
    end else begin
      if (cmd.take) begin
        now_r <= now_ms;
        dt_r <= now_ms - last_sample_time;
        if (line_fault) begin
          fault_cnt <= fault_cnt + 32'd1;
          frame_pos <= 4'd0;
        end else begin
          last_byte_time <= now_ms;
          if (fp_eff == 4'd0) begin
            frame_pos <= (rx_byte == cfg.header_byte) ? 4'd1 : 4'd0;
          end else begin
            payload[3'(fp_eff - 4'd1)] <= rx_byte;
            frame_pos <= (fp_eff == 4'd8) ? 4'd0 : fp_eff + 4'd1;
          end
        end
      end
      if (cmd.reject) fault_cnt <= fault_cnt + 32'd1;
      if (cmd.conv_p) pos_r <= conv_out;
      if (cmd.conv_v) vel_r <= conv_out;
      if (cmd.seed) begin
        seeded <= 1'b1;
        sp <= pos_r;
        sv <= conv_out;
      end
      if (cmd.mul_p || cmd.mul_v) prod_r <= 51'(mul_a * mul_b);
      if (cmd.mul_p) prev_r <= sp;
      if (cmd.add_p) sp <= blend_out;
      if (cmd.add_v) sv <= blend_out;
      if (cmd.reload_v) sv <= vel_r;
      if (cmd.div_init) begin
        dq <= num_mag + {28'd0, dt_r[15:1]};
        neg_r <= num[43];
        rem <= 17'd0;
        cnt <= 6'd0;
      end
      if (cmd.div_step) begin
        cnt <= cnt + 6'd1;
        if (rem_sh >= {1'b0, dt_r[15:0]}) begin
          rem <= rem_sh - {1'b0, dt_r[15:0]};
          dq <= {dq[DivBits-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dq <= {dq[DivBits-2:0], 1'b0};
        end
      end
      if (cmd.div_done) der_r <= q_sat;
      if (cmd.finish) begin
        last_sample_time <= now_r;
        pub_cnt <= pub_cnt + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      report_kind <= cmd.kind;
      position_fx <= sp;
      velocity_mm_s <= sv;
      frames_published <= pub_cnt;
      faults_seen <= fault_cnt;
    end
  end

endmodule

// ===== hw/rtl/sfp_ctrl.sv =====
// Controller state machine sequencing the datapath for each beat.
module sfp_ctrl import sfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rx_valid,
  output logic rx_ready,
  input  logic line_fault,
  output logic rpt_valid,
  input  logic rpt_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_CONV_P   = 12'b0000_0000_0010,
    S_CONV_V   = 12'b0000_0000_0100,
    S_MUL_P    = 12'b0000_0000_1000,
    S_ADD_P    = 12'b0000_0001_0000,
    S_DIV_INIT = 12'b0000_0010_0000,
    S_DIV_RUN  = 12'b0000_0100_0000,
    S_DIV_END  = 12'b0000_1000_0000,
    S_MUL_V    = 12'b0001_0000_0000,
    S_ADD_V    = 12'b0010_0000_0000,
    S_FINISH   = 12'b0100_0000_0000,
    S_PUB      = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  kind_t  kind;
  kind_t  kind_next;
  logic   rpt_valid_next;

  assign rx_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    kind_next = kind;
    cmd = '0;
    cmd.kind = kind;
    case (state)
      S_IDLE: begin
        if (rx_valid) begin
          cmd.take = 1'b1;
          if (line_fault) begin
            kind_next = KIND_FAULT;
            state_next = S_PUB;
          end else if (sts.frame_done) begin
            state_next = S_CONV_P;
          end
        end
      end
      S_CONV_P: begin
        if (sts.nonfinite) begin
          cmd.reject = 1'b1;
          kind_next = KIND_REJECT;
          state_next = S_PUB;
        end else begin
          cmd.conv_p = 1'b1;
          state_next = S_CONV_V;
        end
      end
      S_CONV_V: begin
        cmd.conv_v = 1'b1;
        if (!sts.seeded) begin
          cmd.seed = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_next = S_ADD_P;
      end
      S_ADD_P: begin
        cmd.add_p = 1'b1;
        if (sts.in_window) begin
          state_next = S_DIV_INIT;
        end else begin
          cmd.reload_v = sts.above_max;
          state_next = S_FINISH;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.div_done = 1'b1;
        state_next = S_MUL_V;
      end
      S_MUL_V: begin
        cmd.mul_v = 1'b1;
        state_next = S_ADD_V;
      end
      S_ADD_V: begin
        cmd.add_v = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        kind_next = KIND_SAMPLE;
        state_next = S_PUB;
      end
      S_PUB: begin
        if (!rpt_valid || rpt_ready) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rpt_valid_next = rpt_valid;
    if (rpt_valid && rpt_ready) rpt_valid_next = 1'b0;
    if (cmd.load_out) rpt_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind <= KIND_SAMPLE;
      rpt_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind <= kind_next;
      rpt_valid <= rpt_valid_next;
    end
  end

endmodule

// ===== hw/rtl/sensor_frame_parser_with_smoothing.sv =====
// Top level of the sensor frame parser with position and velocity smoothing.
// A byte beat that does not end a frame is taken in S_IDLE; a line fault beat also passes S_PUB.
// The ninth byte of a frame is checked in S_CONV_P and, if rejected, reported unconverted; else both
// words are converted and the first sample seeds the filter, later ones pass the smoothing states
// and, when the sample interval lies in the window, the 44-step restoring divider that forms
// the derived velocity one quotient bit per cycle. The next byte is taken once the report has
// moved into the output register, which holds it until taken.
module sensor_frame_parser_with_smoothing import sfp_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         now_ms,
  input  logic                line_fault,
  output logic                rpt_valid,
  input  logic                rpt_ready,
  output logic [1:0]          report_kind,
  output logic signed [31:0]  position_fx,
  output logic signed [31:0]  velocity_mm_s,
  output logic [31:0]         frames_published,
  output logic [31:0]         faults_seen
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  sfp_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );

  sfp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .rx_valid(rx_valid), .rx_ready(rx_ready),
    .line_fault(line_fault), .rpt_valid(rpt_valid), .rpt_ready(rpt_ready),
    .sts(sts), .cmd(cmd)
  );

  sfp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .sts(sts),
    .rx_byte(rx_byte), .now_ms(now_ms), .line_fault(line_fault),
    .report_kind(report_kind), .position_fx(position_fx),
    .velocity_mm_s(velocity_mm_s), .frames_published(frames_published),
    .faults_seen(faults_seen)
  );

endmodule

// ===== hw/rtl/sfp_checker.sv =====
// Port-level checks for the sensor frame parser, bound to the top level.
module sfp_checker import sfp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       line_fault,
  input logic       rpt_valid,
  input logic       rpt_ready,
  input logic [1:0] report_kind
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rpt_valid)
    else $error("Report beat valid right after reset.");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> (report_kind == KIND_SAMPLE || report_kind == KIND_REJECT ||
                   report_kind == KIND_FAULT))
    else $error("Report kind outside the defined codes.");

  a_fault_busy: assert property (@(posedge clk) disable iff (rst)
    (rx_valid && rx_ready && line_fault) |=> !rx_ready)
    else $error("Receive side ready while a line fault report is pending.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && !rpt_ready) |=> (rpt_valid && $stable(report_kind)))
    else $error("Stalled report beat changed or vanished.");

endmodule

bind sensor_frame_parser_with_smoothing sfp_checker u_sfp_checker (
  .clk(clk), .rst(rst), .rx_valid(rx_valid), .rx_ready(rx_ready),
  .line_fault(line_fault), .rpt_valid(rpt_valid), .rpt_ready(rpt_ready),
  .report_kind(report_kind)
);

// ===== tb/sensor_frame_parser_with_smoothing_checker.sv =====
// Checker that predicts sensor frame parser reports and compares them with the block's output.
`timescale 1ns / 100ps
module sensor_frame_parser_with_smoothing_checker import sfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  input  logic                rx_valid,
  input  logic                rx_ready,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         now_ms,
  input  logic                line_fault,
  input  logic                rpt_valid,
  input  logic                rpt_ready,
  input  logic [1:0]          report_kind,
  input  logic signed [31:0]  position_fx,
  input  logic signed [31:0]  velocity_mm_s,
  input  logic [31:0]         frames_published,
  input  logic [31:0]         faults_seen,
  output int                  fail_count,
  output int                  pending_reports
);

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic [31:0]        published;
    logic [31:0]        faults;
  } report_t;

  report_t report_queue[$];
  cfg_t    cfg;
  logic [3:0]  frame_pos;
  logic [7:0]  payload[8];
  logic [31:0] last_byte_time;
  logic        seeded;
  logic signed [31:0] s_pos;
  logic signed [31:0] s_vel;
  logic [31:0] last_sample_time;
  logic [31:0] published_count;
  logic [31:0] fault_count;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] float_to_mm(logic [31:0] bits);
    int     ex;
    int     sh;
    longint mant;
    longint mag;
    ex = bits[30:23];
    mant = bits[22:0];
    if (ex != 0) mant = mant | 64'h800000;
    else ex = 1;
    mant = mant * 10;
    sh = ex - 150 + FracBitsDefault;
    if (sh >= 8) mag = 64'd1 << 40;
    else if (sh >= 0) mag = mant << sh;
    else if (sh <= -40) mag = 0;
    else mag = (mant + (64'd1 << (-sh - 1))) >>> (-sh);
    if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
    return bits[31] ? clamp32(-mag) : clamp32(mag);
  endfunction

  function automatic logic signed [31:0] smooth_toward(logic signed [31:0] cur,
                                                        logic signed [31:0] target,
                                                        logic [16:0] w);
    longint p;
    longint r;
    longint wl;
    wl = (w > 17'd65536) ? 65536 : w;
    p = (longint'(target) - longint'(cur)) * wl;
    r = (p >= 0) ? (p + 32768) / 65536 : -((-p + 32768) / 65536);
    return clamp32(longint'(cur) + r);
  endfunction

  function automatic logic signed [31:0] rate_per_s(longint delta, logic [31:0] dt);
    longint num;
    longint d;
    num = delta * 1000;
    d = dt;
    if (num >= 0) return clamp32((num + d / 2) / d);
    return clamp32(-((-num + d / 2) / d));
  endfunction

  function automatic kind_t finish_frame(logic [31:0] now);
    logic [31:0] pbits;
    logic [31:0] vbits;
    logic [31:0] dt;
    logic [31:0] lo;
    logic signed [31:0] p_new;
    logic signed [31:0] v_new;
    logic signed [31:0] prev;
    pbits = {payload[3], payload[2], payload[1], payload[0]};
    vbits = {payload[7], payload[6], payload[5], payload[4]};
    if (&pbits[30:23] || &vbits[30:23]) begin
      fault_count = fault_count + 1;
      return KIND_REJECT;
    end
    p_new = float_to_mm(pbits);
    v_new = float_to_mm(vbits);
    if (!seeded) begin
      seeded = 1'b1;
      s_pos = p_new;
      s_vel = v_new;
    end else begin
      prev = s_pos;
      s_pos = smooth_toward(s_pos, p_new, cfg.position_weight);
      dt = now - last_sample_time;
      lo = (cfg.min_interval_ms == 0) ? 32'd1 : 32'(cfg.min_interval_ms);
      if (dt >= lo && dt <= 32'(cfg.max_interval_ms)) begin
        s_vel = smooth_toward(s_vel,
                              rate_per_s(longint'(s_pos) - longint'(prev), dt),
                              cfg.velocity_weight);
      end else if (dt > 32'(cfg.max_interval_ms)) begin
        s_vel = v_new;
      end
    end
    last_sample_time = now;
    published_count = published_count + 1;
    return KIND_SAMPLE;
  endfunction

  task automatic predict_beat(logic [7:0] b, logic [31:0] now, logic fault);
    kind_t k;
    if (fault) begin
      fault_count = fault_count + 1;
      frame_pos = 0;
      k = KIND_FAULT;
    end else begin
      if (frame_pos != 0 && (now - last_byte_time) > 32'(cfg.gap_timeout_ms)) frame_pos = 0;
      last_byte_time = now;
      if (frame_pos == 0) begin
        if (b == cfg.header_byte) frame_pos = 1;
        return;
      end
      payload[frame_pos - 1] = b;
      frame_pos = frame_pos + 1;
      if (frame_pos <= 8) return;
      frame_pos = 0;
      k = finish_frame(now);
    end
    report_queue.push_back('{k, s_pos, s_vel, published_count, fault_count});
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      cfg = '{HeaderReset, GapReset, MinReset, MaxReset, PosWeightReset, VelWeightReset};
      frame_pos = 0;
      foreach (payload[i]) payload[i] = 8'd0;
      last_byte_time = 0;
      seeded = 1'b0;
      s_pos = 0;
      s_vel = 0;
      last_sample_time = 0;
      published_count = 0;
      fault_count = 0;
      fail_count = 0;
      report_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_HEADER: cfg.header_byte = pwdata[7:0];
          REG_GAP:    cfg.gap_timeout_ms = pwdata[15:0];
          REG_MIN:    cfg.min_interval_ms = pwdata[15:0];
          REG_MAX:    cfg.max_interval_ms = pwdata[15:0];
          REG_POS_W:  cfg.position_weight = pwdata[16:0];
          REG_VEL_W:  cfg.velocity_weight = pwdata[16:0];
          default: ;
        endcase
      end
      if (rpt_valid && rpt_ready) begin
        if (report_queue.size() == 0) begin
          report_mismatch("unexpected beat", report_kind, -1);
        end else begin
          want = report_queue.pop_front();
          if (report_kind !== want.kind) report_mismatch("report_kind", report_kind, want.kind);
          if (position_fx !== want.pos) report_mismatch("position_fx", position_fx, want.pos);
          if (velocity_mm_s !== want.vel)
            report_mismatch("velocity_mm_s", velocity_mm_s, want.vel);
          if (frames_published !== want.published)
            report_mismatch("frames_published", frames_published, want.published);
          if (faults_seen !== want.faults)
            report_mismatch("faults_seen", faults_seen, want.faults);
        end
      end
      if (rx_valid && rx_ready) predict_beat(rx_byte, now_ms, line_fault);
    end
    pending_reports = report_queue.size();
  end

endmodule

// ===== tb/sensor_frame_parser_with_smoothing_tb.sv =====
// Testbench top: drives bytes, register writes and report backpressure, and gives the verdict.
`timescale 1ns / 100ps
module sensor_frame_parser_with_smoothing_tb;
  import sfp_pkg::*;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrBits-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic rx_valid;
  logic rx_ready;
  logic [7:0] rx_byte;
  logic [31:0] now_ms;
  logic line_fault;
  logic rpt_valid;
  logic rpt_ready;
  logic [1:0] report_kind;
  logic signed [31:0] position_fx;
  logic signed [31:0] velocity_mm_s;
  logic [31:0] frames_published;
  logic [31:0] faults_seen;
  int fail_count;
  int pending_reports;
  int cycle_count;
  logic [7:0] header_now;
  logic [31:0] clock_ms;
  bit calm_phase;
  bit sink_on;

  sensor_frame_parser_with_smoothing DUT (.*);

  sensor_frame_parser_with_smoothing_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int burst;
    rpt_ready = 1'b0;
    wait (sink_on);
    forever begin
      @(negedge clk);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 14);
        rpt_ready = 1'b0;
        repeat (burst) @(negedge clk);
      end
      rpt_ready = 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_HEADER) header_now = value[7:0];
  endtask

  task automatic drain_reports();
    while (pending_reports != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_beat(logic [7:0] b, logic [31:0] t, logic fault);
    if (!calm_phase && $urandom_range(0, 7) == 0) begin
      rx_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    rx_valid = 1'b1;
    rx_byte = b;
    now_ms = t;
    line_fault = fault;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    @(negedge clk);
    rx_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 9))
      0: return 32'h7f800000 | ($urandom_range(0, 1) << 31) | $urandom_range(0, 3);
      1: return $urandom_range(0, 1) ? 32'h80000000 : 32'h0;
      2: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
      3: return {$urandom_range(0, 1) == 1, 8'($urandom_range(140, 254)), 23'($urandom)};
      4: return $urandom;
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 135)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_frame(logic [31:0] p_bits, logic [31:0] v_bits, logic [31:0] step);
    logic [63:0] body;
    body = {v_bits, p_bits};
    clock_ms = clock_ms + step;
    send_beat(header_now, clock_ms, 1'b0);
    for (int i = 0; i < 8; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 2);
      send_beat(body[8 * i +: 8], clock_ms, 1'b0);
    end
  endtask

  task automatic random_phase(int count);
    int choice;
    for (int n = 0; n < count; n++) begin
      choice = $urandom_range(0, 19);
      if (choice < 14) begin
        send_frame(pick_float(), pick_float(), $urandom_range(0, 300));
        n = n + 8;
      end else if (choice < 16) begin
        send_beat(8'($urandom), clock_ms, 1'b1);
      end else if (choice < 18) begin
        clock_ms = clock_ms + $urandom_range(0, 30);
        send_beat($urandom_range(0, 1) ? header_now : 8'($urandom), clock_ms, 1'b0);
      end else begin
        send_beat(8'($urandom), $urandom, 1'b0);
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_valid = 1'b0;
    rx_byte = 8'd0;
    now_ms = 32'd0;
    line_fault = 1'b0;
    calm_phase = 1'b0;
    sink_on = 1'b0;
    header_now = HeaderReset;
    clock_ms = 32'd1000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    sink_on = 1'b1;

    send_frame(32'h3f800000, 32'h40000000, 0);
    send_frame(32'h7f7fffff, 32'hff7fffff, 50);
    send_frame(32'h00000001, 32'h80000000, 300);
    send_frame(32'h7fc00000, 32'h3f800000, 20);
    send_beat(8'hff, clock_ms, 1'b1);
    send_beat(header_now, clock_ms, 1'b0);
    send_beat(8'h00, clock_ms + 50, 1'b0);
    send_beat(8'hff, 32'hffff_fff0, 1'b0);
    send_beat(8'h00, 32'h0000_0002, 1'b0);
    clock_ms = 32'd10;
    drain_reports();

    write_reg(REG_HEADER, 32'h00);
    write_reg(REG_GAP, 32'h0);
    write_reg(REG_MIN, 32'h0);
    write_reg(REG_MAX, 32'hffff);
    write_reg(REG_POS_W, 32'd65536);
    write_reg(REG_VEL_W, 32'h1ffff);
    random_phase(300);
    drain_reports();

    write_reg(REG_HEADER, 32'hff);
    write_reg(REG_GAP, 32'hffff);
    write_reg(REG_MIN, 32'd300);
    write_reg(REG_MAX, 32'd1);
    write_reg(REG_POS_W, 32'd0);
    write_reg(REG_VEL_W, 32'd0);
    random_phase(300);
    drain_reports();

    write_reg(REG_HEADER, $urandom);
    write_reg(REG_GAP, $urandom_range(1, 20));
    write_reg(REG_MIN, $urandom_range(1, 20));
    write_reg(REG_MAX, $urandom_range(50, 400));
    write_reg(REG_POS_W, $urandom_range(0, 65536));
    write_reg(REG_VEL_W, $urandom_range(0, 65536));
    random_phase(350);
    calm_phase = 1'b1;
    random_phase(300);
    drain_reports();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
